// ----- hw/rtl/gne_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_pkg: shared types and constants of the grid neighbor expander
// Command, register and offset codes, word formats and helper functions.
// ----------------------------------------------------------------------------
package gne_pkg;

    localparam int CELLS_DEFAULT = 65536;
    localparam int MAX_DIM       = 256;
    localparam int DIM_W         = 9;
    localparam int VERTEX_W      = 16;
    localparam int COORD_W       = 8;
    localparam int IDX_W         = 17;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [DIM_W-1:0] COST_ORTHO = 9'd256;
    localparam logic [DIM_W-1:0] COST_DIAG  = 9'd358;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_EXPAND = 1'b1
    } t_command;

    typedef enum logic [1:0] {
        REG_ROWS  = 2'd0,
        REG_COLS  = 2'd1,
        REG_EIGHT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        STEP_ZERO = 2'b00,
        STEP_NEG  = 2'b01,
        STEP_POS  = 2'b10
    } t_step;

    localparam t_step ROW_STEP [8] = '{
        STEP_ZERO, STEP_ZERO, STEP_NEG, STEP_POS,
        STEP_NEG,  STEP_NEG,  STEP_POS, STEP_POS
    };
    localparam t_step COL_STEP [8] = '{
        STEP_NEG, STEP_POS, STEP_ZERO, STEP_ZERO,
        STEP_NEG, STEP_POS, STEP_NEG,  STEP_POS
    };

    typedef struct packed {
        t_command              command;
        logic [VERTEX_W-1:0]   vertex;
        logic                  blocked;
    } t_cmd;

    typedef struct packed {
        logic [VERTEX_W-1:0] neighbor;
        logic [2:0]          direction;
        logic [DIM_W-1:0]    step_cost;
        logic                found;
        logic                is_last;
    } t_result;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic             eight;
    } t_geom;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM);
        end
        return res;
    endfunction

    function automatic logic [DIM_W-1:0] slot_cost(input logic [2:0] slot);
        return slot[2] ? COST_DIAG : COST_ORTHO;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/grid_neighbor_expander.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// grid_neighbor_expander: occupancy grid neighbor expansion
// Keep a one-bit occupancy map and list the free 4- or 8-connected neighbors
// of a vertex.
//
// Input stream: tuser = command (write or expand), tdata = vertex and blocked.
// A write word stores one cell and produces nothing. An expand word produces
// one output word per free neighbor in slot order, tlast on the final one, or
// a single word with found low and tlast high when no neighbor is free.
// Configuration: APB registers grid_rows, grid_cols and eight_connected at
// byte addresses 0, 4 and 8; write them only while the block is idle.
// Sequence: a write is applied in the sequencer's idle state. An expand pops
// the word and splits it into row and column in the iterative divider, then
// walks the slots one at a time: a rejected slot ends at its bounds check, an
// in-grid slot passes bounds, multiply, occupancy read and check, and a close
// step ends the command. The single occupancy read port sets this order.
// Reset: the map is cleared one cell per cycle, all MAX_CELLS cells, with
// s_axis_tready low; APB writes are taken as usual.
// A stalled receiver holds the output register; a two-word queue keeps
// accepting input words until it fills.
// ----------------------------------------------------------------------------
module grid_neighbor_expander
    import gne_pkg::*;
#(
    parameter int MAX_CELLS = CELLS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [15:0] vertex, [16] blocked
    input  wire logic [0:0]  s_axis_tuser,  // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [15:0] neighbor, [18:16] direction,
                                            // [27:19] step_cost
    output logic      [0:0]  m_axis_tuser,  // [0] found
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [DIM_W-1:0] r_rows;
    logic [DIM_W-1:0] r_cols;
    logic             r_eight;
    logic             cfg_we;
    t_geom            geom;
    t_cmd             in_cmd;
    logic             q_valid;
    t_cmd             q_cmd;
    logic             q_pop;
    logic             clearing;
    t_result          result;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(256);
            r_cols  <= DIM_W'(256);
            r_eight <= 1'b0;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_ROWS:  r_rows  <= pwdata[DIM_W-1:0];
                REG_COLS:  r_cols  <= pwdata[DIM_W-1:0];
                REG_EIGHT: r_eight <= pwdata[0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS:  prdata = 32'(r_rows);
            REG_COLS:  prdata = 32'(r_cols);
            REG_EIGHT: prdata = 32'(r_eight);
            default:   prdata = '0;
        endcase
    end

    assign geom.rows  = clamp_dim(r_rows);
    assign geom.cols  = clamp_dim(r_cols);
    assign geom.eight = r_eight;

    assign in_cmd.command = t_command'(s_axis_tuser[0]);
    assign in_cmd.vertex  = s_axis_tdata[15:0];
    assign in_cmd.blocked = s_axis_tdata[16];

    gne_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_cmd     (in_cmd),
        .i_hold    (clearing),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    gne_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_geom     (geom),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_cmd),
        .o_q_pop    (q_pop),
        .o_clearing (clearing),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (result)
    );

    assign m_axis_tdata = {4'b0, result.step_cost, result.direction, result.neighbor};
    assign m_axis_tuser = result.found;
    assign m_axis_tlast = result.is_last;

endmodule
`default_nettype wire

// ----- hw/rtl/gne_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module gne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gne_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_front: input acceptance and command queue
// Take input words and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module gne_front
    import gne_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    input  wire logic i_hold,
    output logic      o_q_valid,
    output t_cmd      o_q_cmd,
    input  wire logic i_q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_q [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;
    logic             push;
    logic             pop;

    assign o_ready   = !i_hold && (r_count != (PTR_W+1)'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gne_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_div: iterative vertex divider
// Split a vertex index into row and column, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gne_div
    import gne_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [VERTEX_W-1:0] i_dividend,
    input  wire logic [DIM_W-1:0]    i_divisor,
    output logic                     o_done,
    output logic      [VERTEX_W-1:0] o_quot,
    output logic      [COORD_W-1:0]  o_rem
);

    localparam int CNT_W = $clog2(VERTEX_W+1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [VERTEX_W-1:0] r_quot;
    logic [DIM_W-1:0]    r_rem;
    logic [DIM_W-1:0]    r_div;
    logic [DIM_W:0]      trial;
    logic                take;

    assign trial  = {r_rem, r_quot[VERTEX_W-1]};
    assign take   = (trial >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VERTEX_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[VERTEX_W-2:0], take};
            r_rem  <= take ? DIM_W'(trial - {1'b0, r_div}) : trial[DIM_W-1:0];
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gne_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gne_back: occupancy store and neighbor sequencer
// Clear the map after reset, apply cell writes, walk the neighbor slots of an
// expand command and drive result words through an output register.
// ----------------------------------------------------------------------------
module gne_back
    import gne_pkg::*;
#(
    parameter int MAX_CELLS = CELLS_DEFAULT
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_geom   i_geom,
    input  wire logic    i_q_valid,
    input  wire t_cmd    i_q_cmd,
    output logic         o_q_pop,
    output logic         o_clearing,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    localparam int CELL_AW = $clog2(MAX_CELLS);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DIV   = 8'b0000_0100,
        S_SLOT  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_FINAL = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [CELL_AW-1:0]   r_clr_addr;
    logic [2:0]           r_slot, n_slot;
    logic [VERTEX_W-1:0]  r_row;
    logic [COORD_W-1:0]   r_col;
    logic [COORD_W-1:0]   r_nrow;
    logic [COORD_W-1:0]   r_ncol;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_in_store;
    logic                 r_pend_valid, n_pend_valid;
    t_result              r_pend, n_pend;
    logic                 r_out_valid;
    t_result              r_out, n_out;
    logic                 out_load;

    logic                 div_start;
    logic                 div_done;
    logic [VERTEX_W-1:0]  div_quot;
    logic [COORD_W-1:0]   div_rem;

    logic                 ram_we;
    logic [CELL_AW-1:0]   ram_waddr;
    logic                 ram_wdata;
    logic                 ram_re;
    logic                 ram_rdata;

    t_step                row_d, col_d;
    logic [VERTEX_W:0]    row_sum;
    logic [COORD_W:0]     col_sum;
    logic                 slot_ok;
    logic [IDX_W-1:0]     idx_full;
    logic                 load_ok;
    logic                 free;
    logic                 last_slot;
    logic                 write_cmd;
    logic                 write_hit;
    t_result              cand;

    gne_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_q_cmd.vertex),
        .i_divisor  (i_geom.cols),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    gne_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_occ (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (CELL_AW'(r_idx)),
        .o_rdata (ram_rdata)
    );

    assign write_cmd = (r_state == S_IDLE) && i_q_valid && (i_q_cmd.command == CMD_WRITE);
    assign write_hit = write_cmd && (32'(i_q_cmd.vertex) < 32'(MAX_CELLS));
    assign ram_we    = (r_state == S_CLEAR) || write_hit;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : CELL_AW'(i_q_cmd.vertex);
    assign ram_wdata = (r_state == S_CLEAR) ? 1'b0 : i_q_cmd.blocked;
    assign ram_re    = (r_state == S_READ);

    assign o_clearing = (r_state == S_CLEAR);
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign div_start  = o_q_pop && (i_q_cmd.command == CMD_EXPAND);

    always_comb begin
        row_d   = ROW_STEP[r_slot];
        col_d   = COL_STEP[r_slot];
        row_sum = {1'b0, r_row};
        col_sum = {1'b0, r_col};
        slot_ok = 1'b1;
        case (row_d)
            STEP_NEG: begin
                row_sum = {1'b0, r_row} - 1'b1;
                if (r_row == '0) begin
                    slot_ok = 1'b0;
                end
            end
            STEP_POS: row_sum = {1'b0, r_row} + 1'b1;
            default:  row_sum = {1'b0, r_row};
        endcase
        case (col_d)
            STEP_NEG: begin
                col_sum = {1'b0, r_col} - 1'b1;
                if (r_col == '0) begin
                    slot_ok = 1'b0;
                end
            end
            STEP_POS: col_sum = {1'b0, r_col} + 1'b1;
            default:  col_sum = {1'b0, r_col};
        endcase
        if (row_sum >= (VERTEX_W+1)'(i_geom.rows)) begin
            slot_ok = 1'b0;
        end
        if (col_sum >= (COORD_W+1)'(i_geom.cols)) begin
            slot_ok = 1'b0;
        end
    end

    assign idx_full  = IDX_W'(r_nrow) * IDX_W'(i_geom.cols) + IDX_W'(r_ncol);
    assign last_slot = i_geom.eight ? (r_slot == 3'd7) : (r_slot == 3'd3);
    assign load_ok   = !r_out_valid || i_ready;
    assign free      = r_in_store && !ram_rdata;

    always_comb begin
        cand.neighbor  = r_idx[VERTEX_W-1:0];
        cand.direction = r_slot;
        cand.step_cost = slot_cost(r_slot);
        cand.found     = 1'b1;
        cand.is_last   = 1'b0;
    end

    always_comb begin
        n_state      = r_state;
        n_slot       = r_slot;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_pend;
        out_load     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == CELL_AW'(MAX_CELLS-1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (div_start) begin
                    n_state      = S_DIV;
                    n_slot       = '0;
                    n_pend_valid = 1'b0;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                if (slot_ok) begin
                    n_state = S_MUL;
                end else if (last_slot) begin
                    n_state = S_FINAL;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!(free && r_pend_valid && !load_ok)) begin
                    if (free) begin
                        out_load     = r_pend_valid;
                        n_pend       = cand;
                        n_pend_valid = 1'b1;
                    end
                    if (last_slot) begin
                        n_state = S_FINAL;
                    end else begin
                        n_slot  = r_slot + 1'b1;
                        n_state = S_SLOT;
                    end
                end
            end
            S_FINAL: begin
                if (load_ok) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    if (r_pend_valid) begin
                        n_out.is_last = 1'b1;
                    end else begin
                        n_out = '{neighbor: '0, direction: '0, step_cost: '0,
                                  found: 1'b0, is_last: 1'b1};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_slot       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_slot       <= n_slot;
            r_pend_valid <= n_pend_valid;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (out_load) begin
            r_out <= n_out;
        end
        if (r_state == S_DIV && div_done) begin
            r_row <= div_quot;
            r_col <= div_rem;
        end
        if (r_state == S_SLOT) begin
            r_nrow <= row_sum[COORD_W-1:0];
            r_ncol <= col_sum[COORD_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_idx      <= idx_full;
            r_in_store <= (32'(idx_full) < 32'(MAX_CELLS));
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- sim/tb_grid_neighbor_expander.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_neighbor_expander: self-checking bench for the grid neighbor expander
// Streams write and expand words into the block under several grid shapes
// and idle/stall profiles. A scoreboard keeps its own occupancy map and
// geometry, lists the free neighbors of every accepted expand word, and
// checks each output word field by field in arrival order.
// ----------------------------------------------------------------------------
import gne_pkg::*;

class neighbor_scoreboard;
    logic [65535:0]   occupied;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic             eight_reg;
    t_result          pending[$];
    int               mismatches;
    int               expands;
    int               writes;
    int               result_words;
    int               markers;

    function new();
        occupied     = '0;
        rows_reg     = DIM_W'(MAX_DIM);
        cols_reg     = DIM_W'(MAX_DIM);
        eight_reg    = 1'b0;
        mismatches   = 0;
        expands      = 0;
        writes       = 0;
        result_words = 0;
        markers      = 0;
    endfunction

    function int eff_dim(logic [DIM_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > DIM_W'(MAX_DIM)) return MAX_DIM;
        return int'(raw);
    endfunction

    function void set_register(t_reg_idx idx, logic [31:0] value);
        case (idx)
            REG_ROWS:  rows_reg  = value[DIM_W-1:0];
            REG_COLS:  cols_reg  = value[DIM_W-1:0];
            REG_EIGHT: eight_reg = value[0];
            default: ;
        endcase
    endfunction

    function void note_command(t_cmd word);
        int      rows;
        int      cols;
        int      r;
        int      c;
        int      nr;
        int      nc;
        int      idx;
        int      slots;
        int      row_off [8];
        int      col_off [8];
        t_result res;
        t_result held;
        logic    have_held;
        row_off = '{0, 0, -1, 1, -1, -1, 1, 1};
        col_off = '{-1, 1, 0, 0, -1, 1, -1, 1};
        if (word.command == CMD_WRITE) begin
            writes++;
            occupied[word.vertex] = word.blocked;
            return;
        end
        expands++;
        rows      = eff_dim(rows_reg);
        cols      = eff_dim(cols_reg);
        r         = int'(word.vertex) / cols;
        c         = int'(word.vertex) % cols;
        slots     = eight_reg ? 8 : 4;
        have_held = 1'b0;
        held      = '0;
        for (int s = 0; s < slots; s++) begin
            nr = r + row_off[s];
            nc = c + col_off[s];
            if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
            idx = nr * cols + nc;
            if (idx >= 65536) continue;
            if (occupied[idx]) continue;
            res.neighbor  = idx[VERTEX_W-1:0];
            res.direction = s[2:0];
            res.step_cost = (s < 4) ? COST_ORTHO : COST_DIAG;
            res.found     = 1'b1;
            res.is_last   = 1'b0;
            if (have_held) pending = {pending, held};
            held      = res;
            have_held = 1'b1;
        end
        // an expand with no free neighbor still closes with one marker word
        if (!have_held) held = '0;
        held.is_last = 1'b1;
        pending = {pending, held};
    endfunction

    function void report_field(string name, int want, int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual %h", $time, got);
            return;
        end
        want = pending.pop_front();
        result_words++;
        if (!want.found) markers++;
        report_field("neighbor", want.neighbor, got.neighbor);
        report_field("direction", want.direction, got.direction);
        report_field("step_cost", want.step_cost, got.step_cost);
        report_field("found", want.found, got.found);
        report_field("is_last", want.is_last, got.is_last);
    endfunction
endclass

module tb_grid_neighbor_expander;

    localparam int HALF_PERIOD   = 10;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 82;
    localparam int WINDOW        = 512;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [15:0] vertex, [16] blocked
    logic [0:0]  s_axis_tuser  = '0;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [15:0] neighbor, [18:16] direction, [27:19] step_cost
    logic [0:0]  m_axis_tuser;         // [0] found
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          idle_pct      = 0;
    int          stall_pct     = 0;
    int          window_base   = 0;
    logic        hold_rx       = 1'b0;

    neighbor_scoreboard board;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    grid_neighbor_expander DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
                got.neighbor  = m_axis_tdata[15:0];
                got.direction = m_axis_tdata[18:16];
                got.step_cost = m_axis_tdata[27:19];
                got.found     = m_axis_tuser[0];
                got.is_last   = m_axis_tlast;
                board.check_result(got);
            end
            if (hold_rx) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(t_command cmd, logic [15:0] vertex, logic blocked);
        t_cmd word;
        word.command = cmd;
        word.vertex  = vertex;
        word.blocked = blocked;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, blocked, vertex};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        board.note_command(word);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic set_geometry(int rows, int cols, logic eight);
        int span;
        drain();
        write_reg(REG_ROWS, ($urandom() & ~32'h1FF) | (rows & 32'h1FF));
        write_reg(REG_COLS, ($urandom() & ~32'h1FF) | (cols & 32'h1FF));
        write_reg(REG_EIGHT, ($urandom() & ~32'h1) | 32'(eight));
        span = board.eff_dim(board.rows_reg) * board.eff_dim(board.cols_reg);
        window_base = (span > WINDOW) ? $urandom_range(span - WINDOW) : 0;
    endtask

    function automatic logic [15:0] pick_vertex();
        int span;
        int width;
        span  = board.eff_dim(board.rows_reg) * board.eff_dim(board.cols_reg);
        width = (span < WINDOW) ? span : WINDOW;
        if ($urandom_range(99) < 15) return 16'($urandom_range(65535));
        return 16'(window_base + $urandom_range(width - 1));
    endfunction

    task automatic random_words(int count);
        repeat (count) begin
            if ($urandom_range(99) < 35) begin
                send_word(CMD_WRITE, pick_vertex(), $urandom_range(99) < 35);
            end else begin
                send_word(CMD_EXPAND, pick_vertex(), 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic hold_receiver(int cycles);
        hold_rx <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_rx <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_geometry(4, 4, 1'b1);
        send_word(CMD_EXPAND, 16'd0, 1'b0);
        send_word(CMD_EXPAND, 16'd5, 1'b1);
        send_word(CMD_EXPAND, 16'd15, 1'b0);
        send_word(CMD_EXPAND, 16'd16, 1'b0);
        send_word(CMD_EXPAND, 16'hFFFF, 1'b0);
        send_word(CMD_WRITE, 16'd1, 1'b1);
        send_word(CMD_WRITE, 16'd4, 1'b1);
        send_word(CMD_WRITE, 16'd5, 1'b1);
        send_word(CMD_EXPAND, 16'd0, 1'b0);
        send_word(CMD_EXPAND, 16'd6, 1'b0);
        send_word(CMD_WRITE, 16'hFFFF, 1'b1);
        send_word(CMD_WRITE, 16'd5, 1'b0);
        send_word(CMD_EXPAND, 16'd0, 1'b0);
        set_geometry(4, 4, 1'b0);
        send_word(CMD_EXPAND, 16'd5, 1'b0);
        send_word(CMD_EXPAND, 16'd3, 1'b0);
        set_geometry(0, 0, 1'b0);
        send_word(CMD_EXPAND, 16'd0, 1'b0);
        send_word(CMD_EXPAND, 16'd1, 1'b0);
        set_geometry(511, 300, 1'b1);
        send_word(CMD_EXPAND, 16'd0, 1'b0);
        send_word(CMD_EXPAND, 16'hFFFF, 1'b0);
        send_word(CMD_EXPAND, 16'hFFFE, 1'b0);
        send_word(CMD_EXPAND, 16'd257, 1'b0);

        set_geometry(8, 8, 1'b1);
        random_words(RANDOM_WORDS);

        idle_pct  = 80;
        stall_pct = 0;
        set_geometry(5, 13, 1'b0);
        random_words(RANDOM_WORDS);

        idle_pct  = 0;
        stall_pct = 80;
        set_geometry(1, 256, 1'b1);
        random_words(RANDOM_WORDS);

        idle_pct  = 13;
        stall_pct = 13;
        set_geometry(256, 1, 1'b0);
        random_words(RANDOM_WORDS);

        idle_pct  = 0;
        stall_pct = 0;
        set_geometry(256, 256, 1'b1);
        fork
            hold_receiver(HOLD_CYCLES);
        join_none
        repeat (20) send_word(CMD_EXPAND, pick_vertex(), 1'b0);
        random_words(RANDOM_WORDS);

        drain();
        if (board.pending.size() != 0) board.mismatches++;
        $display("Run covered %0d write and %0d expand words, %0d result words, %0d empty",
                 board.writes, board.expands, board.result_words, board.markers);
        $display("Grids from 1x1 to 256x256, clamped sizes, 4/8-connected, idle and stall mixes");
        if (board.mismatches == 0) begin
            $display("grid_neighbor_expander verification clean");
        end else begin
            $display("grid_neighbor_expander verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("grid_neighbor_expander verification failed");
        $finish;
    end

endmodule
